[rtl/vtm_pkg.sv]
// shared types, constants and codes for the virtual timer multiplexer
`timescale 1ns / 1ps

package vtm_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int IDX_W      = 3;
  localparam int ACTIVE_W   = 4;
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
  localparam int REQ_W      = 3;
  localparam int BASE_W     = 16;
  localparam int VAL_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 40;

  localparam logic [BASE_W-1:0] BASE_MAX = 16'hFFFF;

  localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SET    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REBASE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CHECK  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TIMERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPIRED_MARK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHRON_START   = 2'd2;

  typedef struct packed {
    logic [ACTIVE_W-1:0] used_timers;
    logic [VAL_W-1:0]    expired_mark;
    logic [VAL_W-1:0]    chron_start;
  } vtm_cfg_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [IDX_W-1:0]  timer_index;
    logic [BASE_W-1:0] base_ticks;
    logic [VAL_W-1:0]  timer_ticks;
  } vtm_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             expired;
    logic             stopped;
    logic             event_pending;
    logic             index_rejected;
  } vtm_result_t;

  typedef struct packed {
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
    logic             sub;
    logic [VAL_W-1:0] ca;
    logic [VAL_W-1:0] cb;
  } vtm_alu_req_t;

  typedef struct packed {
    logic [VAL_W-1:0] res;
    logic             borrow;
    logic             lt;
    logic             eq;
  } vtm_alu_rsp_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [VAL_W-1:0] data;
  } vtm_bank_wr_t;

endpackage

[rtl/vtm_alu.sv]
// shared adder-subtractor and magnitude comparator
`timescale 1ns / 1ps

module vtm_alu (
  input  vtm_pkg::vtm_alu_req_t req,
  output vtm_pkg::vtm_alu_rsp_t rsp
);

  logic [vtm_pkg::VAL_W:0] sum;

  always_comb begin
    if (req.sub) begin
      sum = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      sum = {1'b0, req.a} + {1'b0, req.b};
    end
    rsp.res    = sum[vtm_pkg::VAL_W-1:0];
    rsp.borrow = sum[vtm_pkg::VAL_W];
    rsp.lt     = req.ca < req.cb;
    rsp.eq     = req.ca == req.cb;
  end

endmodule

[rtl/vtm_count_bank.sv]
// virtual timer count storage, one write and one read port
`timescale 1ns / 1ps

module vtm_count_bank (
  input  logic                         clk,
  input  logic                         rst,
  input  vtm_pkg::vtm_bank_wr_t        wr,
  input  logic [vtm_pkg::IDX_W-1:0]    raddr,
  output logic [vtm_pkg::VAL_W-1:0]    rdata
);

  logic [vtm_pkg::VAL_W-1:0] counts [vtm_pkg::NUM_TIMERS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vtm_pkg::NUM_TIMERS; i++) begin
        counts[i] <= '0;
      end
    end else if (wr.we) begin
      counts[wr.addr] <= wr.data;
    end
  end

  assign rdata = counts[raddr];

endmodule

[rtl/vtm_seq.sv]
// request sequencer driving the shared alu and the count bank
`timescale 1ns / 1ps

module vtm_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  vtm_pkg::vtm_cfg_t         cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  vtm_pkg::vtm_item_t        in_item,
  output logic                      res_valid,
  input  logic                      res_ready,
  output vtm_pkg::vtm_result_t      res_out
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_SET2  = 4'd2;
  localparam logic [3:0] S_SET3  = 4'd3;
  localparam logic [3:0] S_RD2   = 4'd4;
  localparam logic [3:0] S_RD3   = 4'd5;
  localparam logic [3:0] S_RBA   = 4'd6;
  localparam logic [3:0] S_RBB   = 4'd7;
  localparam logic [3:0] S_RBEND = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam int BW = vtm_pkg::BASE_W;
  localparam int VW = vtm_pkg::VAL_W;

  logic [3:0] state, state_next;
  logic [vtm_pkg::CNT_W-1:0] cnt, cnt_next;
  logic [vtm_pkg::CNT_W-1:0] cnt_inc;
  vtm_pkg::vtm_item_t item, item_next;
  vtm_pkg::vtm_result_t res, res_next;
  logic [BW-1:0] spent, spent_next;
  logic [VW-1:0] tmp, tmp_next;
  logic [VW-1:0] newc, newc_next;
  logic live, live_next;
  logic [VW-1:0] low, low_next;
  logic found, found_next;
  logic [BW-1:0] base_remaining, base_remaining_next;
  logic [BW-1:0] base_loaded, base_loaded_next;
  logic timer_event, timer_event_next;

  vtm_pkg::vtm_alu_req_t alu_req;
  vtm_pkg::vtm_alu_rsp_t alu_rsp;
  vtm_pkg::vtm_bank_wr_t bank_wr;
  logic [vtm_pkg::IDX_W-1:0] raddr;
  logic [VW-1:0] rdata;

  logic [BW-1:0] t_clamp;
  logic [BW-1:0] low16;
  logic addressed;
  logic index_ok;

  vtm_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  vtm_count_bank u_bank (
    .clk   (clk),
    .rst   (rst),
    .wr    (bank_wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign t_clamp   = (|item.timer_ticks[VW-1:BW]) ? vtm_pkg::BASE_MAX
                                                  : item.timer_ticks[BW-1:0];
  assign low16     = !found ? '0 :
                     (|low[VW-1:BW]) ? vtm_pkg::BASE_MAX : low[BW-1:0];
  assign addressed = (item.req_type == vtm_pkg::REQ_SET) ||
                     (item.req_type == vtm_pkg::REQ_CHECK) ||
                     (item.req_type == vtm_pkg::REQ_READ);
  assign index_ok  = vtm_pkg::CNT_W'(item.timer_index) < vtm_pkg::CNT_W'(cfg.used_timers);
  assign cnt_inc   = cnt + vtm_pkg::CNT_W'(1);

  always_comb begin
    state_next          = state;
    cnt_next            = cnt;
    item_next           = item;
    res_next            = res;
    spent_next          = spent;
    tmp_next            = tmp;
    newc_next           = newc;
    live_next           = live;
    low_next            = low;
    found_next          = found;
    base_remaining_next = base_remaining;
    base_loaded_next    = base_loaded;
    timer_event_next    = timer_event;
    alu_req             = '0;
    bank_wr             = '0;
    raddr               = item.timer_index;
    in_ready            = 1'b0;
    res_valid           = 1'b0;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_next  = in_item;
          res_next   = '0;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        if (addressed && !index_ok) begin
          res_next.index_rejected = 1'b1;
        end else begin
          case (item.req_type)
            vtm_pkg::REQ_TICK: begin
              alu_req.a   = VW'(base_remaining);
              alu_req.b   = VW'(item.base_ticks);
              alu_req.sub = 1'b1;
              if (alu_rsp.borrow || alu_rsp.res == '0) begin
                if (base_remaining != '0) begin
                  timer_event_next    = 1'b1;
                  base_remaining_next = '0;
                end
              end else begin
                base_remaining_next = alu_rsp.res[BW-1:0];
              end
            end
            vtm_pkg::REQ_LOAD: begin
              base_remaining_next = item.base_ticks;
              base_loaded_next    = item.base_ticks;
            end
            vtm_pkg::REQ_SET: begin
              if (item.timer_ticks == '0) begin
                bank_wr.we       = 1'b1;
                bank_wr.addr     = item.timer_index;
                bank_wr.data     = '0;
                res_next.stopped = 1'b1;
              end else if (base_remaining == '0 && !timer_event) begin
                bank_wr.we          = 1'b1;
                bank_wr.addr        = item.timer_index;
                bank_wr.data        = item.timer_ticks;
                base_remaining_next = t_clamp;
                base_loaded_next    = t_clamp;
              end else begin
                alu_req.a   = VW'(base_loaded);
                alu_req.b   = VW'(base_remaining);
                alu_req.sub = 1'b1;
                spent_next  = alu_rsp.res[BW-1:0];
                state_next  = S_SET2;
              end
            end
            vtm_pkg::REQ_REBASE: begin
              cnt_next   = '0;
              low_next   = cfg.expired_mark;
              found_next = 1'b0;
              state_next = (cfg.used_timers == '0) ? S_RBEND : S_RBA;
            end
            vtm_pkg::REQ_CHECK: begin
              alu_req.ca = rdata;
              alu_req.cb = cfg.expired_mark;
              if (alu_rsp.eq) begin
                bank_wr.we       = 1'b1;
                bank_wr.addr     = item.timer_index;
                bank_wr.data     = '0;
                res_next.expired = 1'b1;
                res_next.stopped = 1'b1;
              end else begin
                res_next.stopped = rdata == '0;
              end
            end
            vtm_pkg::REQ_READ: begin
              alu_req.a   = VW'(base_loaded);
              alu_req.b   = VW'(base_remaining);
              alu_req.sub = 1'b1;
              spent_next  = alu_rsp.res[BW-1:0];
              state_next  = S_RD2;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_SET2: begin
        alu_req.a        = item.timer_ticks;
        alu_req.b        = VW'(spent);
        bank_wr.we       = 1'b1;
        bank_wr.addr     = item.timer_index;
        bank_wr.data     = alu_rsp.res;
        res_next.stopped = alu_rsp.res == '0;
        state_next       = S_SET3;
      end
      S_SET3: begin
        alu_req.a  = VW'(t_clamp);
        alu_req.b  = VW'(spent);
        alu_req.ca = VW'(t_clamp);
        alu_req.cb = VW'(base_remaining);
        if (alu_rsp.lt) begin
          base_loaded_next    = alu_rsp.res[BW-1:0];
          base_remaining_next = t_clamp;
        end
        state_next = S_DONE;
      end
      S_RD2: begin
        alu_req.a   = cfg.chron_start;
        alu_req.b   = rdata;
        alu_req.sub = 1'b1;
        tmp_next    = alu_rsp.res;
        state_next  = S_RD3;
      end
      S_RD3: begin
        alu_req.a        = tmp;
        alu_req.b        = VW'(spent);
        res_next.value   = alu_rsp.res;
        res_next.stopped = rdata == '0;
        state_next       = S_DONE;
      end
      S_RBA: begin
        raddr       = cnt[vtm_pkg::IDX_W-1:0];
        alu_req.ca  = rdata;
        alu_req.cb  = cfg.expired_mark;
        alu_req.a   = rdata;
        alu_req.b   = VW'(base_loaded);
        alu_req.sub = 1'b1;
        live_next   = (rdata != '0) && alu_rsp.lt;
        newc_next   = (!alu_rsp.borrow && alu_rsp.res != '0) ? alu_rsp.res
                                                             : cfg.expired_mark;
        state_next  = S_RBB;
      end
      S_RBB: begin
        raddr        = cnt[vtm_pkg::IDX_W-1:0];
        bank_wr.we   = live;
        bank_wr.addr = cnt[vtm_pkg::IDX_W-1:0];
        bank_wr.data = newc;
        alu_req.ca   = newc;
        alu_req.cb   = low;
        if (live && alu_rsp.lt) begin
          low_next   = newc;
          found_next = 1'b1;
        end
        cnt_next   = cnt_inc;
        state_next = (cnt_inc == vtm_pkg::CNT_W'(cfg.used_timers)) ? S_RBEND : S_RBA;
      end
      S_RBEND: begin
        timer_event_next    = 1'b0;
        base_remaining_next = low16;
        base_loaded_next    = low16;
        res_next.value      = VW'(low16);
        state_next          = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_out               = res;
    res_out.event_pending = timer_event;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cnt            <= '0;
      base_remaining <= '0;
      base_loaded    <= '0;
      timer_event    <= 1'b0;
    end else begin
      state          <= state_next;
      cnt            <= cnt_next;
      base_remaining <= base_remaining_next;
      base_loaded    <= base_loaded_next;
      timer_event    <= timer_event_next;
    end
  end

  always_ff @(posedge clk) begin
    item  <= item_next;
    res   <= res_next;
    spent <= spent_next;
    tmp   <= tmp_next;
    newc  <= newc_next;
    live  <= live_next;
    low   <= low_next;
    found <= found_next;
  end

endmodule

[rtl/virtual_timer_multiplexer.sv]
// top level: configuration registers, stream unpacking and output register
`timescale 1ns / 1ps

// Virtual timer multiplexer: eight 32-bit virtual timers over one 16-bit base.
// Requests enter on the s_axis channel, one item each, with the request code in
// tuser; each request gives exactly one result item on the m_axis channel.
// Configuration writes go through cfg_valid/cfg_index/cfg_data, always ready; the user
// must make them while no request is in progress, which the block itself does not enforce.
// A request is taken only while the sequencer is idle. Each request passes
// through S_EXEC and S_DONE, from which its result moves into the output
// register. A nonzero set while the base runs or an event is pending goes
// through S_SET2 and S_SET3 before S_DONE, an elapsed read through S_RD2 and
// S_RD3, and a rebase through S_RBA and S_RBB for each active timer and then
// S_RBEND. The rebase walk over the timers, on the shared subtractor and
// comparator, sets the longest case.
// The result sits in an output register; the next request is taken as soon as
// the result is registered, even while the receiver stalls. A second result
// waits in the sequencer until the output register is free.
// Reset clears all timers, the base, the event flag and the output valid flag,
// and restores the configuration registers to eight timers, all-ones mark and
// all-ones start value.
module virtual_timer_multiplexer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // timer_index, base_ticks, timer_ticks, zero fill
  input  logic [vtm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // req_type
  input  logic [vtm_pkg::REQ_W-1:0]           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // value, expired, stopped, event_pending, index_rejected, zero fill
  output logic [vtm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vtm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vtm_pkg::VAL_W-1:0]           cfg_data
);

  logic [vtm_pkg::ACTIVE_W-1:0] active_timers;
  logic [vtm_pkg::VAL_W-1:0]    expired_mark;
  logic [vtm_pkg::VAL_W-1:0]    chron_start;

  vtm_pkg::vtm_cfg_t    cfg;
  vtm_pkg::vtm_item_t   in_item;
  vtm_pkg::vtm_result_t res;
  logic                 res_valid;
  logic                 res_ready;
  logic                 out_valid;
  vtm_pkg::vtm_result_t out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_timers <= vtm_pkg::ACTIVE_W'(8);
      expired_mark  <= '1;
      chron_start   <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vtm_pkg::CFG_ACTIVE_TIMERS: active_timers <= cfg_data[vtm_pkg::ACTIVE_W-1:0];
        vtm_pkg::CFG_EXPIRED_MARK:  expired_mark  <= cfg_data;
        vtm_pkg::CFG_CHRON_START:   chron_start   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.used_timers  = (active_timers > vtm_pkg::ACTIVE_W'(vtm_pkg::NUM_TIMERS))
                       ? vtm_pkg::ACTIVE_W'(vtm_pkg::NUM_TIMERS) : active_timers;
    cfg.expired_mark = expired_mark;
    cfg.chron_start  = chron_start;
  end

  always_comb begin
    in_item.req_type    = s_axis_tuser;
    in_item.timer_index = s_axis_tdata[2:0];
    in_item.base_ticks  = s_axis_tdata[18:3];
    in_item.timer_ticks = s_axis_tdata[50:19];
  end

  vtm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_out   (res)
  );

  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0, out_res.index_rejected, out_res.event_pending,
                          out_res.stopped, out_res.expired, out_res.value};

endmodule

[rtl/vtm_checker.sv]
// port-level checks for the virtual timer multiplexer, bound to the top level
`timescale 1ns / 1ps

module vtm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [vtm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one request at a time
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // a rejected index leaves value, expired and stopped at zero
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[35] |->
      m_axis_tdata[31:0] == '0 && !m_axis_tdata[32] && !m_axis_tdata[33])
    else $error("rejected request carries data");

  // an expired result also reports the timer stopped
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[33])
    else $error("expired without stopped");

endmodule

bind virtual_timer_multiplexer vtm_checker u_vtm_checker (.*);
